[sv/dda_line_rasterizer_top_defines.svh]
// Assertion macros used by the line rasteriser controller.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DDA_LINE_RASTERIZER_TOP_DEFINES_SVH
`define DDA_LINE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define DDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define DDA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dda_pkg.sv]
// Shared types and constants of the DDA line rasteriser.
// No dependencies; every other file of the block but the assertion macro header uses it.
package dda_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_start;  // start beat accepted: load endpoints and emit start point
    logic adv_step;  // step beat accepted: advance the line and emit a point
    logic div_iter;  // one restoring division iteration on both lanes
    logic div_fin;   // round the quotients and load the increments
  } dda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_len;  // endpoints of the offered start beat coincide
  } dda_stat_t;

endpackage

[sv/dda_if.sv]
// Handshake channels of the DDA line rasteriser: input and output beats.
// Depends on dda_pkg for the default coordinate width.
interface dda_in_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_out_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         point_valid;
  logic                         last_point;

  modport source (output valid, pixel_x, pixel_y, point_valid, last_point, input ready);
  modport sink   (input valid, pixel_x, pixel_y, point_valid, last_point, output ready);
endinterface

[sv/dda_line_rasterizer_top.sv]
// DDA line rasteriser, top level: wires the controller to the datapath.
// Depends on dda_pkg, dda_if, dda_ctrl and dda_dpath.
//
// Usage: beats arrive on in_i and every accepted beat yields exactly one
// beat on out_o. A start beat (cmd = 0) carries both endpoints and returns
// the start point; a step beat (cmd = 1) advances the line by one step and
// returns the next point, with last_point set on the final one. A step with
// no line in progress returns a beat with point_valid low.
// The result is registered: it is in the output register in the cycle after acceptance.
// Throughput: step beats go at one per cycle while the receiver keeps up.
// After a start beat the input stays blocked while the two restoring
// dividers work out the increments, one quotient bit per cycle, and while
// they are rounded. A start beat for a zero-length line blocks nothing.
// Reset clears the line state to idle and empties the output register.
// When the receiver stalls, the result is held and one further beat is
// taken only in the cycle in which the held result leaves.
module dda_line_rasterizer_top #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  dda_in_if.sink    in_i,
  dda_out_if.source out_o
);

  dda_pkg::dda_cmd_t  cmd;
  dda_pkg::dda_stat_t stat;

  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dda_dpath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .x_start_i     (in_i.x_start),
    .y_start_i     (in_i.y_start),
    .x_end_i       (in_i.x_end),
    .y_end_i       (in_i.y_end),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .point_valid_o (out_o.point_valid),
    .last_point_o  (out_o.last_point)
  );

endmodule

[sv/dda_ctrl.sv]
// Controller of the DDA line rasteriser: handshakes, output valid and the
// division sequence. Depends on dda_pkg and dda_line_rasterizer_top_defines.svh.
`include "dda_line_rasterizer_top_defines.svh"

module dda_ctrl #(
  parameter int unsigned FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dda_pkg::dda_stat_t stat_i,
  output dda_pkg::dda_cmd_t  cmd_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  // A new beat may enter while idle, once the output register is free or being emptied.
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.ld_start = accept && (in_cmd_i == dda_pkg::CMD_START);
    cmd_o.adv_step = accept && (in_cmd_i == dda_pkg::CMD_STEP);
    out_valid_d    = accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.ld_start && !stat_i.zero_len) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cmd_o.div_iter = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DDA_ASSERT_IMP(a_no_overwrite, accept && out_valid_q, out_ready_i,
                  "result overwritten before it was taken")
  `DDA_ASSERT_NXT(a_div_to_fin, (state_q == ST_DIV) && (cnt_q == CNT_LAST),
                  state_q == ST_FIN, "division did not finish after its last iteration")
  `DDA_ASSERT_NXT(a_start_busy, cmd_o.ld_start && !stat_i.zero_len, !in_ready_o,
                  "input taken while increments are being divided")
  `DDA_ASSERT_NXT(a_fin_idle, state_q == ST_FIN, state_q == ST_IDLE,
                  "controller did not return to idle after the increments")

endmodule

[sv/dda_dpath.sv]
// Datapath of the DDA line rasteriser: accumulators, increment dividers,
// rounding and the output register. Depends on dda_pkg.
module dda_dpath #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dda_pkg::dda_cmd_t            cmd_i,
  output dda_pkg::dda_stat_t           stat_o,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         point_valid_o,
  output logic                         last_point_o
);

  localparam int unsigned ACC_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_W = FRAC_BITS + 2;
  localparam int unsigned CNT_W  = COORD_BITS + 1;
  localparam int unsigned PIX_W  = COORD_BITS + 2;

  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [PIX_W-1:0] PIX_MIN = ~PIX_MAX;

  // Accumulator to integer, rounded half away from zero, saturated.
  // A negative value rounds as (a + half - 1) shifted down arithmetically.
  function automatic logic [COORD_BITS-1:0] to_pixel(input logic [ACC_W-1:0] a);
    logic [ACC_W:0]          sum;
    logic signed [PIX_W-1:0] v;
    sum = {a[ACC_W-1], a} + HALF - (ACC_W + 1)'(a[ACC_W-1]);
    v   = $signed(sum[ACC_W:FRAC_BITS]);
    if (v > PIX_MAX) begin
      v = PIX_MAX;
    end else if (v < PIX_MIN) begin
      v = PIX_MIN;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Endpoint deltas and step count for a start beat.
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        ax_w, ay_w;
  logic [COORD_BITS-1:0]      ax, ay, steps;

  assign dx    = $signed({x_end_i[COORD_BITS-1], x_end_i})
               - $signed({x_start_i[COORD_BITS-1], x_start_i});
  assign dy    = $signed({y_end_i[COORD_BITS-1], y_end_i})
               - $signed({y_start_i[COORD_BITS-1], y_start_i});
  assign ax_w  = dx[COORD_BITS] ? -dx : dx;
  assign ay_w  = dy[COORD_BITS] ? -dy : dy;
  assign ax    = ax_w[COORD_BITS-1:0];
  assign ay    = ay_w[COORD_BITS-1:0];
  assign steps = (ax > ay) ? ax : ay;

  assign stat_o.zero_len = (x_start_i == x_end_i) && (y_start_i == y_end_i);

  // Line state.
  logic [ACC_W-1:0]  acc_x_q, acc_y_q;
  logic [STEP_W-1:0] step_x_q, step_y_q;
  logic [CNT_W-1:0]  steps_left_q;
  logic              line_active_q;

  // Divider state: one restoring divider per axis, sharing the divisor.
  logic [COORD_BITS-1:0] div_q;
  logic [COORD_BITS:0]   rem_x_q, rem_y_q;
  logic [FRAC_BITS:0]    quo_x_q, quo_y_q;
  logic                  neg_x_q, neg_y_q;

  logic                  ge_x, ge_y;
  logic [COORD_BITS:0]   r_x, r_y;
  logic [STEP_W-1:0]     mag_x, mag_y;

  assign ge_x  = rem_x_q >= {1'b0, div_q};
  assign ge_y  = rem_y_q >= {1'b0, div_q};
  assign r_x   = ge_x ? rem_x_q - {1'b0, div_q} : rem_x_q;
  assign r_y   = ge_y ? rem_y_q - {1'b0, div_q} : rem_y_q;
  // After the last iteration the remainder registers hold twice the remainder.
  assign mag_x = {1'b0, quo_x_q} + STEP_W'(ge_x);
  assign mag_y = {1'b0, quo_y_q} + STEP_W'(ge_y);

  logic [ACC_W-1:0] acc_x_nx, acc_y_nx;

  assign acc_x_nx = acc_x_q + {{(ACC_W - STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
  assign acc_y_nx = acc_y_q + {{(ACC_W - STEP_W){step_y_q[STEP_W-1]}}, step_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      step_x_q      <= '0;
      step_y_q      <= '0;
      steps_left_q  <= '0;
      line_active_q <= 1'b0;
    end else begin
      if (cmd_i.ld_start) begin
        acc_x_q       <= {x_start_i[COORD_BITS-1], x_start_i, {FRAC_BITS{1'b0}}};
        acc_y_q       <= {y_start_i[COORD_BITS-1], y_start_i, {FRAC_BITS{1'b0}}};
        step_x_q      <= '0;
        step_y_q      <= '0;
        steps_left_q  <= CNT_W'(steps);
        line_active_q <= !stat_o.zero_len;
      end else if (cmd_i.adv_step && line_active_q) begin
        acc_x_q      <= acc_x_nx;
        acc_y_q      <= acc_y_nx;
        steps_left_q <= steps_left_q - 1'b1;
        if (steps_left_q == CNT_W'(1)) begin
          line_active_q <= 1'b0;
        end
      end else if (cmd_i.div_fin) begin
        step_x_q <= neg_x_q ? -mag_x : mag_x;
        step_y_q <= neg_y_q ? -mag_y : mag_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_start) begin
      div_q   <= steps;
      rem_x_q <= {1'b0, ax};
      rem_y_q <= {1'b0, ay};
      quo_x_q <= '0;
      quo_y_q <= '0;
      neg_x_q <= dx[COORD_BITS];
      neg_y_q <= dy[COORD_BITS];
    end else if (cmd_i.div_iter) begin
      rem_x_q <= {r_x[COORD_BITS-1:0], 1'b0};
      rem_y_q <= {r_y[COORD_BITS-1:0], 1'b0};
      quo_x_q <= {quo_x_q[FRAC_BITS-1:0], ge_x};
      quo_y_q <= {quo_y_q[FRAC_BITS-1:0], ge_y};
    end
  end

  // Output register; it is only written when a beat is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_start) begin
      pixel_x_o     <= x_start_i;
      pixel_y_o     <= y_start_i;
      point_valid_o <= 1'b1;
      last_point_o  <= stat_o.zero_len;
    end else if (cmd_i.adv_step) begin
      if (line_active_q) begin
        pixel_x_o     <= to_pixel(acc_x_nx);
        pixel_y_o     <= to_pixel(acc_y_nx);
        point_valid_o <= 1'b1;
        last_point_o  <= (steps_left_q == CNT_W'(1));
      end else begin
        pixel_x_o     <= '0;
        pixel_y_o     <= '0;
        point_valid_o <= 1'b0;
        last_point_o  <= 1'b0;
      end
    end
  end

endmodule

[bench/tb_dda_line_rasterizer_top.sv]
// Self-checking testbench for the DDA line rasteriser: directed and random lines,
// predicted points compared beat by beat under source gaps and sink stalls.
// Depends on dda_pkg, dda_if and the dda_line_rasterizer_top RTL.
module tb_dda_line_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = dda_pkg::COORD_BITS_DEF;
  localparam int unsigned FB = dda_pkg::FRAC_BITS_DEF;
  localparam int unsigned AB = CB + FB + 1;
  localparam int CMAX = (1 << (CB - 1)) - 1;
  localparam int CMIN = -(1 << (CB - 1));
  localparam int unsigned SETTLE = FB + 4;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic          pv;
    logic          last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dda_in_if  #(.COORD_BITS(CB)) in_bus ();
  dda_out_if #(.COORD_BITS(CB)) out_bus ();

  dda_line_rasterizer_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #1 clk = ~clk;

  // Line state as the block should hold it.
  longint          acc_x, acc_y, inc_x, inc_y;
  longint unsigned steps_rem;
  bit              line_on;

  point_t          pending_points[$];
  int unsigned     mismatches;
  longint unsigned cycle_count;
  int unsigned     send_idle_pct;
  int unsigned     sink_stall_pct;
  bit              sink_hold;

  function automatic longint wrap_acc(longint v);
    longint modulus;
    modulus = longint'(1) << AB;
    v = v & (modulus - 1);
    if (v >= modulus / 2) v = v - modulus;
    return v;
  endfunction

  // Delta scaled to fixed point and divided by the step count, rounded half away from zero.
  function automatic longint fixed_incr(longint d, longint n);
    longint num, q;
    num = (d < 0 ? -d : d) << FB;
    q = (2 * num + n) / (2 * n);
    return d < 0 ? -q : q;
  endfunction

  function automatic logic [CB-1:0] round_pixel(longint a);
    longint r, v;
    r = ((a < 0 ? -a : a) + (longint'(1) << (FB - 1))) >> FB;
    v = a < 0 ? -r : r;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return CB'(v);
  endfunction

  function automatic point_t next_point(logic cmd, logic [CB-1:0] xs, logic [CB-1:0] ys,
                                        logic [CB-1:0] xe, logic [CB-1:0] ye);
    point_t p;
    longint sx, sy, dx, dy, ax, ay, n;
    p = '{px: '0, py: '0, pv: 1'b0, last: 1'b0};
    if (cmd == dda_pkg::CMD_START) begin
      sx = longint'($signed(xs));
      sy = longint'($signed(ys));
      dx = longint'($signed(xe)) - sx;
      dy = longint'($signed(ye)) - sy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      n = ax > ay ? ax : ay;
      acc_x = wrap_acc(sx * (longint'(1) << FB));
      acc_y = wrap_acc(sy * (longint'(1) << FB));
      if (n == 0) begin
        inc_x = 0;
        inc_y = 0;
        steps_rem = 0;
        line_on = 1'b0;
      end else begin
        inc_x = fixed_incr(dx, n);
        inc_y = fixed_incr(dy, n);
        steps_rem = n;
        line_on = 1'b1;
      end
    end else if (line_on) begin
      acc_x = wrap_acc(acc_x + inc_x);
      acc_y = wrap_acc(acc_y + inc_y);
      steps_rem = steps_rem - 1;
      if (steps_rem == 0) line_on = 1'b0;
    end else begin
      // A step with no line in progress returns an empty beat.
      return p;
    end
    p.px = round_pixel(acc_x);
    p.py = round_pixel(acc_y);
    p.pv = 1'b1;
    p.last = !line_on;
    return p;
  endfunction

  function automatic logic [CB-1:0] noise_field();
    return CB'($urandom());
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(7))
      0: return CMIN;
      1: return CMAX;
      default: return int'($urandom_range(CMAX - CMIN)) + CMIN;
    endcase
  endfunction

  function automatic int clip_coord(int v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  task automatic send_beat(logic cmd, logic [CB-1:0] xs, logic [CB-1:0] ys,
                           logic [CB-1:0] xe, logic [CB-1:0] ye);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.cmd = cmd;
    in_bus.x_start = xs;
    in_bus.y_start = ys;
    in_bus.x_end = xe;
    in_bus.y_end = ye;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_points.push_back(next_point(cmd, xs, ys, xe, ye));
  endtask

  task automatic send_step();
    send_beat(dda_pkg::CMD_STEP, noise_field(), noise_field(), noise_field(), noise_field());
  endtask

  task automatic send_line(int xs, int ys, int xe, int ye);
    send_beat(dda_pkg::CMD_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye));
  endtask

  // Drops valid and holds the source back until every point has been returned.
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  // Mostly complete lines with random endpoints; some are cut short by a new start,
  // some run on into steps with no line, and the rest is loose steps and wild starts.
  task automatic run_line_mix(int unsigned n_items);
    int unsigned sent, n_steps, len, spread, i, pick;
    int sx, sy, ex, ey, adx, ady;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        sx = rand_coord();
        sy = rand_coord();
        spread = ($urandom_range(19) == 0) ? 300 : 12;
        ex = clip_coord(sx + int'($urandom_range(2 * spread)) - int'(spread));
        ey = clip_coord(sy + int'($urandom_range(2 * spread)) - int'(spread));
        if ($urandom_range(15) == 0) begin
          ex = sx;
          ey = sy;
        end
        adx = ex > sx ? ex - sx : sx - ex;
        ady = ey > sy ? ey - sy : sy - ey;
        len = adx > ady ? adx : ady;
        case ($urandom_range(9))
          0: n_steps = $urandom_range(len);
          1: n_steps = len + $urandom_range(3, 1);
          default: n_steps = len;
        endcase
        send_line(sx, sy, ex, ey);
        sent++;
        for (i = 0; i < n_steps; i++) begin
          send_step();
          sent++;
        end
      end else if (pick < 93) begin
        send_step();
        sent++;
      end else begin
        send_beat(dda_pkg::CMD_START, noise_field(), noise_field(), noise_field(),
                  noise_field());
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    sink_stall_pct = 0;
    send_step();
    // Zero-length line at the corner of the range, then a step that finds no line.
    send_line(CMIN, CMAX, CMIN, CMAX);
    send_step();
    // Horizontal line with exact unit increments, then a step past its end.
    send_line(-3, 5, 2, 5);
    repeat (5) send_step();
    send_step();
    // Steep line with fractional x increments.
    send_line(10, -10, 8, -5);
    repeat (5) send_step();
    // Half-pixel points on the negative side round away from zero.
    send_line(-1, 0, -2, 2);
    repeat (2) send_step();
    // Full-range diagonals; the first is abandoned by the second start, neither runs to its end.
    send_line(CMIN, CMIN, CMAX, CMAX);
    repeat (3) send_step();
    send_line(CMAX, CMIN, CMIN, CMAX);
    repeat (2) send_step();
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    run_line_mix(340);
    wait_drained();
  endtask

  // The sink holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk);
        sink_hold = 1'b0;
      end
      run_line_mix(60);
    join
    wait_drained();
  endtask

  task automatic check_field(string name, logic [CB-1:0] want, logic [CB-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    out_bus.ready = !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_points.size() == 0) begin
        $error("output beat with no point expected");
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("pixel_x", want.px, out_bus.pixel_x);
        check_field("pixel_y", want.py, out_bus.pixel_y);
        check_field("point_valid", CB'(want.pv), CB'(out_bus.point_valid));
        check_field("last_point", CB'(want.last), CB'(out_bus.last_point));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_dda_line_rasterizer_top: done, errors");
      $finish;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.cmd = dda_pkg::CMD_START;
    in_bus.x_start = '0;
    in_bus.y_start = '0;
    in_bus.x_end = '0;
    in_bus.y_end = '0;
    out_bus.ready = 1'b0;
    sink_hold = 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    acc_x = 0;
    acc_y = 0;
    inc_x = 0;
    inc_y = 0;
    steps_rem = 0;
    line_on = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(0, 0);
    test_random_phase(63, 0);
    test_random_phase(0, 63);
    test_random_phase(35, 35);
    test_backpressure();

    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("tb_dda_line_rasterizer_top: done, clean");
    end else begin
      $display("tb_dda_line_rasterizer_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/dda_pkg.sv
sv/dda_if.sv
sv/dda_ctrl.sv
sv/dda_dpath.sv
sv/dda_line_rasterizer_top.sv
bench/tb_dda_line_rasterizer_top.sv
